// ===== rtl/ebfr_pkg.sv =====
// Package: types, codes and helpers for the echo bit frame receiver.
package ebfr_pkg;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_TYPE = 6'b000010,
		PH_SRC  = 6'b000100,
		PH_DST  = 6'b001000,
		PH_LEN  = 6'b010000,
		PH_DATA = 6'b100000
	} phase_t;

	typedef logic [2:0] field_code_t;

	localparam field_code_t FC_TYPE = 3'd0;
	localparam field_code_t FC_SRC  = 3'd1;
	localparam field_code_t FC_DST  = 3'd2;
	localparam field_code_t FC_LEN  = 3'd3;
	localparam field_code_t FC_DATA = 3'd4;

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t CFG_TYPE_BITS    = 3'd0;
	localparam cfg_index_t CFG_ADDRESS_BITS = 3'd1;
	localparam cfg_index_t CFG_LENGTH_BITS  = 3'd2;
	localparam cfg_index_t CFG_DATA_TYPE    = 3'd3;
	localparam cfg_index_t CFG_MAX_ECHO     = 3'd4;
	localparam cfg_index_t CFG_NO_ECHO      = 3'd5;

	localparam logic [3:0]  RST_TYPE_BITS    = 4'd4;
	localparam logic [3:0]  RST_ADDRESS_BITS = 4'd8;
	localparam logic [3:0]  RST_LENGTH_BITS  = 4'd8;
	localparam logic [7:0]  RST_DATA_TYPE    = 8'd2;
	localparam logic [15:0] RST_MAX_ECHO     = 16'd65279;
	localparam logic [15:0] RST_NO_ECHO      = 16'd0;

	localparam logic [3:0] MAX_FIELD_W = 4'd8;

	// Zero acts as one bit, anything above eight as eight.
	function automatic logic [3:0] clamp_width(input logic [3:0] w);
		logic [3:0] r;
		if (w == 4'd0) begin
			r = 4'd1;
		end else if (w > MAX_FIELD_W) begin
			r = MAX_FIELD_W;
		end else begin
			r = w;
		end
		return r;
	endfunction

endpackage

// ===== rtl/echo_bit_frame_receiver_core.sv =====
// Top level: echo bit frame receiver, one echo time per bit slot.
//
// Input channel in_valid/in_ready carries one echo_time item per bit slot.
// While idle, an echo different from the no-echo register starts a frame;
// every later item decodes to one bit (1 if nonzero and below max_echo).
// Fields (type, source, destination, and for data frames length plus data
// bytes) are shifted in MSB first, each followed by an odd parity bit.
// On every parity slot one result item leaves on out_valid/out_ready.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready. The user must write it only while the block is idle; the block does not enforce it.
// An accepted item waits in the input register and is decoded from there;
// its result, if any, is registered and shown on the outputs.
// Throughput: one item per cycle unless a result is stalled on out_ready,
// set by the input register, the decode logic and the result register.
// Reset clears the frame state to idle and loads the register defaults.
// When out_ready is low with a result waiting, the decode stage holds its
// item and in_ready falls once the input register is full.
module echo_bit_frame_receiver_core #(
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [15:0]          echo_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ebfr_pkg::field_code_t field_code,
	output logic [7:0]           field_value,
	output logic                 parity_ok,
	output logic                 frame_end,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  ebfr_pkg::cfg_index_t cfg_index,
	input  logic [15:0]          cfg_data
);
	import ebfr_pkg::*;

	localparam logic [3:0] DATA_W = clamp_width(4'(DATA_BITS));

	logic [3:0]  type_bits_q, address_bits_q, length_bits_q;
	logic [7:0]  data_type_q;
	logic [15:0] max_echo_q, no_echo_q;

	logic        valid_s1;
	logic [15:0] echo_s1;

	phase_t      phase_q, phase_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  held_type_q, held_type_d;
	logic [7:0]  bytes_left_q, bytes_left_d;

	logic        out_valid_q;
	field_code_t code_q;
	logic [7:0]  value_q;
	logic        ok_q, end_q;

	logic        proc;
	logic        echo_bit;
	logic [3:0]  width;
	logic        res_valid, res_ok, res_end;
	field_code_t res_code;
	logic [7:0]  bytes_dec;

	assign cfg_ready = 1'b1;
	assign proc      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_bits_q    <= RST_TYPE_BITS;
			address_bits_q <= RST_ADDRESS_BITS;
			length_bits_q  <= RST_LENGTH_BITS;
			data_type_q    <= RST_DATA_TYPE;
			max_echo_q     <= RST_MAX_ECHO;
			no_echo_q      <= RST_NO_ECHO;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TYPE_BITS:    type_bits_q    <= cfg_data[3:0];
				CFG_ADDRESS_BITS: address_bits_q <= cfg_data[3:0];
				CFG_LENGTH_BITS:  length_bits_q  <= cfg_data[3:0];
				CFG_DATA_TYPE:    data_type_q    <= cfg_data[7:0];
				CFG_MAX_ECHO:     max_echo_q     <= cfg_data;
				CFG_NO_ECHO:      no_echo_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			echo_s1 <= echo_time;
		end
	end

	assign echo_bit  = (echo_s1 != 16'd0) && (echo_s1 < max_echo_q);
	assign bytes_dec = 8'(bytes_left_q - 8'd1);

	always_comb begin
		unique case (phase_q)
			PH_TYPE:        width = clamp_width(type_bits_q);
			PH_SRC, PH_DST: width = clamp_width(address_bits_q);
			PH_LEN:         width = clamp_width(length_bits_q);
			default:        width = DATA_W;
		endcase
	end

	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		shift_d      = shift_q;
		held_type_d  = held_type_q;
		bytes_left_d = bytes_left_q;
		res_valid    = 1'b0;
		res_ok       = 1'b0;
		res_end      = 1'b0;
		res_code     = FC_TYPE;
		if (phase_q == PH_IDLE) begin
			if (echo_s1 != no_echo_q) begin
				phase_d     = PH_TYPE;
				bit_count_d = 4'd0;
				shift_d     = 8'd0;
			end
		end else if (bit_count_q < width) begin
			shift_d     = {shift_q[6:0], echo_bit};
			bit_count_d = 4'(bit_count_q + 4'd1);
		end else begin
			res_valid   = 1'b1;
			res_ok      = echo_bit != (^shift_q);
			bit_count_d = 4'd0;
			shift_d     = 8'd0;
			unique case (phase_q)
				PH_TYPE: begin
					res_code = FC_TYPE;
					if (res_ok) held_type_d = shift_q;
					phase_d = PH_SRC;
				end
				PH_SRC: begin
					res_code = FC_SRC;
					phase_d  = PH_DST;
				end
				PH_DST: begin
					res_code = FC_DST;
					res_end  = held_type_q != data_type_q;
					phase_d  = PH_LEN;
				end
				PH_LEN: begin
					res_code = FC_LEN;
					if (res_ok) bytes_left_d = shift_q;
					res_end = shift_q == 8'd0;
					phase_d = PH_DATA;
				end
				default: begin
					res_code = FC_DATA;
					if (res_ok) bytes_left_d = bytes_dec;
					res_end = bytes_dec == 8'd0;
					phase_d = PH_DATA;
				end
			endcase
			if (!res_ok) res_end = 1'b1;
			if (res_end) phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= 4'd0;
			shift_q      <= 8'd0;
			held_type_q  <= 8'd0;
			bytes_left_q <= 8'd0;
		end else if (proc) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
			held_type_q  <= held_type_d;
			bytes_left_q <= bytes_left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			code_q  <= res_code;
			value_q <= shift_q;
			ok_q    <= res_ok;
			end_q   <= res_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign field_code  = code_q;
	assign field_value = value_q;
	assign parity_ok   = ok_q;
	assign frame_end   = end_q;

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parity_ok |-> frame_end)
		else $error("parity error without frame end");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		proc && res_valid && res_end |=> phase_q == PH_IDLE)
		else $error("frame end did not return to idle");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> field_code <= FC_DATA)
		else $error("field code out of range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= MAX_FIELD_W)
		else $error("bit count past widest field");

endmodule

// ===== sim/testbench.sv =====
// Testbench for the echo bit frame receiver: directed and random frames checked against a predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ebfr_pkg::*;

	localparam int DATA_W = 8;

	typedef struct packed {
		field_code_t code;
		logic [7:0]  value;
		logic        ok;
		logic        last;
	} field_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] echo_time;
	logic        out_valid;
	logic        out_ready;
	field_code_t field_code;
	logic [7:0]  field_value;
	logic        parity_ok;
	logic        frame_end;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_index_t  cfg_index;
	logic [15:0] cfg_data;

	// register copies
	logic [3:0]  reg_type_bits;
	logic [3:0]  reg_address_bits;
	logic [3:0]  reg_length_bits;
	logic [7:0]  reg_data_type;
	logic [15:0] reg_max_echo;
	logic [15:0] reg_no_echo;

	// frame decoder state
	phase_t      pr_phase;
	logic [3:0]  pr_count;
	logic [7:0]  pr_shift;
	logic [7:0]  pr_type;
	logic [7:0]  pr_left;

	field_result_t expected_fields[$];
	int errors;
	int items_sent;
	int gap_pct;
	int stall_pct;
	int hold_request;
	int hold_left;

	echo_bit_frame_receiver_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.echo_time   (echo_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.field_code  (field_code),
		.field_value (field_value),
		.parity_ok   (parity_ok),
		.frame_end   (frame_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10ms;
		$display("testbench failed");
		$finish;
	end

	// receiver side: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic void report(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		field_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_fields.size() == 0) begin
				$display("%0t unexpected result: expected none, actual code %0d value %0d",
					$time, field_code, field_value);
				errors++;
			end else begin
				want = expected_fields.pop_front();
				report("field_code", int'(want.code), int'(field_code));
				report("field_value", int'(want.value), int'(field_value));
				report("parity_ok", int'(want.ok), int'(parity_ok));
				report("frame_end", int'(want.last), int'(frame_end));
			end
		end
	end

	function automatic int field_width(phase_t ph);
		int w;
		case (ph)
			PH_TYPE: w = int'(reg_type_bits);
			PH_SRC, PH_DST: w = int'(reg_address_bits);
			PH_LEN: w = int'(reg_length_bits);
			default: w = DATA_W;
		endcase
		if (w < 1) w = 1;
		if (w > 8) w = 8;
		return w;
	endfunction

	function automatic void reset_decoder();
		reg_type_bits = RST_TYPE_BITS;
		reg_address_bits = RST_ADDRESS_BITS;
		reg_length_bits = RST_LENGTH_BITS;
		reg_data_type = RST_DATA_TYPE;
		reg_max_echo = RST_MAX_ECHO;
		reg_no_echo = RST_NO_ECHO;
		pr_phase = PH_IDLE;
		pr_count = '0;
		pr_shift = '0;
		pr_type = '0;
		pr_left = '0;
	endfunction

	// one bit slot: start a frame while idle, shift a field bit, or check parity and queue the field
	function automatic void decode_echo(logic [15:0] e);
		logic b;
		int w;
		field_result_t r;
		if (pr_phase == PH_IDLE) begin
			if (e != reg_no_echo) begin
				pr_phase = PH_TYPE;
				pr_count = '0;
				pr_shift = '0;
			end
			return;
		end
		b = (e != 16'd0) && (e < reg_max_echo);
		w = field_width(pr_phase);
		if (pr_count < w) begin
			pr_shift = {pr_shift[6:0], b};
			pr_count++;
			return;
		end
		case (pr_phase)
			PH_TYPE: r.code = FC_TYPE;
			PH_SRC: r.code = FC_SRC;
			PH_DST: r.code = FC_DST;
			PH_LEN: r.code = FC_LEN;
			default: r.code = FC_DATA;
		endcase
		r.value = pr_shift;
		r.ok = (b != ^pr_shift);
		r.last = !r.ok;
		if (r.ok) begin
			case (pr_phase)
				PH_TYPE: pr_type = pr_shift;
				PH_DST: if (pr_type != reg_data_type) r.last = 1'b1;
				PH_LEN: begin
					pr_left = pr_shift;
					if (pr_left == 8'd0) r.last = 1'b1;
				end
				PH_DATA: begin
					pr_left = pr_left - 8'd1;
					if (pr_left == 8'd0) r.last = 1'b1;
				end
				default: ;
			endcase
		end
		if (r.last) begin
			pr_phase = PH_IDLE;
		end else begin
			case (pr_phase)
				PH_TYPE: pr_phase = PH_SRC;
				PH_SRC: pr_phase = PH_DST;
				PH_DST: pr_phase = PH_LEN;
				default: pr_phase = PH_DATA;
			endcase
		end
		pr_count = '0;
		pr_shift = '0;
		expected_fields.push_back(r);
	endfunction

	task automatic send_echo(input logic [15:0] e);
		in_valid <= 1'b1;
		echo_time <= e;
		do @(posedge clk); while (!in_ready);
		if (!(pr_phase == PH_IDLE && e == reg_no_echo)) items_sent++;
		decode_echo(e);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
	endtask

	task automatic drain_fields();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_fields.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
		drain_fields();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TYPE_BITS: reg_type_bits = data[3:0];
			CFG_ADDRESS_BITS: reg_address_bits = data[3:0];
			CFG_LENGTH_BITS: reg_length_bits = data[3:0];
			CFG_DATA_TYPE: reg_data_type = data[7:0];
			CFG_MAX_ECHO: reg_max_echo = data;
			CFG_NO_ECHO: reg_no_echo = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random upper bits on top of the register value
	task automatic write_widths(input logic [3:0] tw, input logic [3:0] aw, input logic [3:0] lw);
		logic [15:0] d;
		d = 16'($urandom);
		d[3:0] = tw;
		write_reg(CFG_TYPE_BITS, d);
		d = 16'($urandom);
		d[3:0] = aw;
		write_reg(CFG_ADDRESS_BITS, d);
		d = 16'($urandom);
		d[3:0] = lw;
		write_reg(CFG_LENGTH_BITS, d);
	endtask

	function automatic logic [15:0] echo_for_bit(logic b);
		int pick;
		pick = $urandom_range(9);
		if (b && reg_max_echo > 16'd1) begin
			if (pick == 0) return 16'd1;
			if (pick == 1) return reg_max_echo - 16'd1;
			return 16'($urandom_range(1, reg_max_echo - 1));
		end
		if (pick < 4) return 16'd0;
		if (pick == 4) return reg_max_echo;
		if (pick == 5) return 16'hFFFF;
		return 16'($urandom_range(reg_max_echo, 16'hFFFF));
	endfunction

	function automatic logic [15:0] start_echo();
		logic [15:0] e;
		do begin
			e = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
		end while (e == reg_no_echo);
		return e;
	endfunction

	// bring the decoder back to idle, breaking parity to end a frame quickly
	task automatic settle_frame();
		logic [15:0] e;
		while (pr_phase != PH_IDLE) begin
			if (pr_count >= field_width(pr_phase)) e = echo_for_bit(^pr_shift);
			else e = 16'($urandom);
			send_echo(e);
		end
	endtask

	task automatic send_field(input logic [7:0] value, input int w, input logic bad);
		logic p;
		p = ~(^value) ^ bad;
		for (int i = w - 1; i >= 0; i--) send_echo(echo_for_bit(value[i]));
		send_echo(echo_for_bit(p));
	endtask

	// bad_at: 0 type, 1 source, 2 destination, 3 length, 4+k data byte k; -1 none
	task automatic send_frame(input logic [7:0] ftype, input logic [7:0] src,
			input logic [7:0] dst, input logic [7:0] len, input int bad_at);
		int tw, aw, lw;
		logic [7:0] mask;
		settle_frame();
		tw = field_width(PH_TYPE);
		aw = field_width(PH_SRC);
		lw = field_width(PH_LEN);
		mask = 8'hFF >> (8 - tw);
		ftype &= mask;
		mask = 8'hFF >> (8 - aw);
		src &= mask;
		dst &= mask;
		mask = 8'hFF >> (8 - lw);
		len &= mask;
		send_echo(start_echo());
		send_field(ftype, tw, bad_at == 0);
		if (bad_at == 0) return;
		send_field(src, aw, bad_at == 1);
		if (bad_at == 1) return;
		send_field(dst, aw, bad_at == 2);
		if (bad_at == 2 || ftype != reg_data_type) return;
		send_field(len, lw, bad_at == 3);
		if (bad_at == 3) return;
		for (int k = 0; k < len; k++) begin
			send_field(8'($urandom), DATA_W, bad_at == 4 + k);
			if (bad_at == 4 + k) return;
		end
	endtask

	task automatic random_frame();
		logic [7:0] ftype, len;
		int bad_at;
		ftype = ($urandom_range(99) < 60) ? reg_data_type : 8'($urandom);
		if ($urandom_range(99) < 4) len = 8'($urandom_range(0, 31));
		else len = 8'($urandom_range(0, 4));
		bad_at = ($urandom_range(99) < 12) ? $urandom_range(0, 5 + len) : -1;
		send_frame(ftype, 8'($urandom), 8'($urandom), len, bad_at);
	endtask

	task automatic noise_burst();
		int n;
		logic [15:0] e;
		n = $urandom_range(1, 12);
		repeat (n) begin
			case ($urandom_range(5))
				0: e = 16'd0;
				1: e = reg_no_echo;
				2: e = reg_max_echo;
				3: e = reg_max_echo - 16'd1;
				4: e = 16'hFFFF;
				default: e = 16'($urandom);
			endcase
			send_echo(e);
		end
	endtask

	task automatic set_idling(input int gap, input int stall);
		gap_pct = gap;
		stall_pct = stall;
	endtask

	task automatic random_config();
		logic [3:0] tw;
		int w;
		logic [15:0] d;
		tw = 4'($urandom_range(0, 15));
		write_widths(tw, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
		w = field_width(PH_TYPE);
		d = 16'($urandom);
		if ($urandom_range(99) < 75) d[7:0] = 8'($urandom_range(0, (1 << w) - 1));
		write_reg(CFG_DATA_TYPE, d);
		if ($urandom_range(99) < 80) write_reg(CFG_MAX_ECHO, 16'($urandom_range(16'h0100, 16'hFFFF)));
		else write_reg(CFG_MAX_ECHO, 16'($urandom));
		write_reg(CFG_NO_ECHO, ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom));
	endtask

	task automatic test_idle_echo();
		send_echo(reg_no_echo);
		send_echo(reg_no_echo);
		drain_fields();
	endtask

	task automatic test_reset_frames();
		send_frame(8'd2, 8'hFF, 8'h00, 8'd0, -1);
		send_frame(8'h0F, 8'h00, 8'hFF, 8'd0, -1);
		send_frame(8'h0F, 8'h5A, 8'h00, 8'd0, 0);
		settle_frame();
		drain_fields();
	endtask

	task automatic test_width_clamps();
		write_widths(4'd0, 4'd0, 4'd15);
		write_reg(CFG_DATA_TYPE, 16'hA501);
		// longest length, broken on the second data byte
		send_frame(8'd1, 8'd1, 8'd0, 8'd255, 5);
		send_frame(8'd0, 8'd0, 8'd1, 8'd0, -1);
		send_frame(8'd1, 8'd0, 8'd1, 8'd2, -1);
		repeat (6) random_frame();
		settle_frame();
		drain_fields();
	endtask

	task automatic test_code_extremes();
		write_widths(4'd8, 4'd8, 4'd8);
		write_reg(CFG_DATA_TYPE, 16'h00FF);
		write_reg(CFG_MAX_ECHO, 16'hFFFF);
		write_reg(CFG_NO_ECHO, 16'hFFFF);
		send_echo(16'hFFFF);
		send_frame(8'hFF, 8'hFF, 8'hFF, 8'd1, -1);
		write_reg(CFG_DATA_TYPE, 16'hFF00);
		send_frame(8'h00, 8'h00, 8'h00, 8'd1, -1);
		send_frame(8'h00, 8'hAA, 8'h55, 8'd0, 3);
		settle_frame();
		drain_fields();
	endtask

	task automatic test_max_echo_extremes();
		write_widths(4'd2, 4'd2, 4'd2);
		write_reg(CFG_MAX_ECHO, 16'd0);
		write_reg(CFG_NO_ECHO, 16'd0);
		repeat (3) random_frame();
		settle_frame();
		write_reg(CFG_MAX_ECHO, 16'd1);
		repeat (3) random_frame();
		settle_frame();
		write_reg(CFG_MAX_ECHO, 16'd2);
		repeat (3) random_frame();
		settle_frame();
		drain_fields();
	endtask

	task automatic test_random_traffic(input int gap, input int stall, input int count);
		int stop_at;
		random_config();
		set_idling(gap, stall);
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			case ($urandom_range(9))
				0: noise_burst();
				1: send_frame(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom_range(0, 3)), $urandom_range(0, 6));
				default: random_frame();
			endcase
		end
		settle_frame();
		drain_fields();
		set_idling(0, 0);
	endtask

	task automatic test_backpressure();
		write_widths(4'd4, 4'd3, 4'd3);
		write_reg(CFG_DATA_TYPE, 16'd2);
		write_reg(CFG_MAX_ECHO, 16'hFF00);
		write_reg(CFG_NO_ECHO, 16'd0);
		set_idling(0, 0);
		hold_request = 400;
		repeat (12) send_frame(8'd2, 8'($urandom), 8'($urandom), 8'($urandom_range(1, 4)), -1);
		settle_frame();
		drain_fields();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		echo_time = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TYPE_BITS;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		gap_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		reset_decoder();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_echo();
		test_reset_frames();
		test_width_clamps();
		test_code_extremes();
		test_max_echo_extremes();
		test_random_traffic(0, 0, 325);
		test_random_traffic(50, 0, 325);
		test_random_traffic(0, 50, 325);
		test_random_traffic(25, 25, 325);
		test_backpressure();

		drain_fields();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

// ===== echo_bit_frame_receiver_core.f =====
rtl/ebfr_pkg.sv
rtl/echo_bit_frame_receiver_core.sv
sim/testbench.sv
